// ===== hw/rtl/lir_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lir_pkg
// Shared constants and types for the linear interpolation resampler.
// ----------------------------------------------------------------------------
package lir_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int FRAC_BITS    = 16;
  localparam int MAX_UPSAMPLE = 8;

  localparam int STEP_W      = 20;
  localparam int CFG_DATA_W  = 20;
  localparam int CFG_IDX_W   = 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [STEP_W-1:0] STEP_RESET   = STEP_W'(65536);
  localparam logic              BYPASS_RESET = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_Q16 = 1'b0,
    CFG_BYPASS   = 1'b1
  } cfg_index_t;

  typedef enum logic {
    CMD_BYPASS   = 1'b0,
    CMD_INTERVAL = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    logic      last;
  } cmd_ctrl_t;

  localparam int CTRL_W = $bits(cmd_ctrl_t);

endpackage
`default_nettype wire

// ===== hw/rtl/lir_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lir_in_if
// Input sample channel: valid/ready with one sample and its end-of-stream mark.
// ----------------------------------------------------------------------------
interface lir_in_if #(
  parameter int SAMPLE_WIDTH = lir_pkg::SAMPLE_WIDTH
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] in_sample;
  logic                           last_sample;

  modport source (output valid, output in_sample, output last_sample, input ready);
  modport sink   (input valid, input in_sample, input last_sample, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/lir_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lir_out_if
// Result channel: valid/ready with one output sample and its run/stream marks.
// ----------------------------------------------------------------------------
interface lir_out_if #(
  parameter int SAMPLE_WIDTH = lir_pkg::SAMPLE_WIDTH
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] out_sample;
  logic                           last_of_run;
  logic                           stream_end;

  modport source (output valid, output out_sample, output last_of_run,
                  output stream_end, input ready);
  modport sink   (input valid, input out_sample, input last_of_run,
                  input stream_end, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/linear_interp_resampler_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// linear_interp_resampler_core
// Streaming linear-interpolation sample-rate converter with bypass.
//
//   channel   dir  handshake     payload
//   samples   in   valid/ready   in_sample, last_sample
//   results   out  valid/ready   out_sample, last_of_run, stream_end
//   cfg       in   cfg_we        cfg_index, cfg_data (step_q16, bypass)
//
// Each interpolating input yields 0..MAX_UPSAMPLE results; the position
// sequencer issues one product per cycle through the single multiplier while
// the product stage is free, and pops no new command until the current one
// is done. Bypass inputs yield one result each. A command passes the queue,
// the work register and the product stage into the output register. In
// interpolating mode a first sample of a stream only updates the front. Reset
// is synchronous and clears all control state. A stalled result register
// holds; the front keeps accepting until the command queue is full.
// ----------------------------------------------------------------------------
module linear_interp_resampler_core #(
  parameter int SAMPLE_WIDTH = lir_pkg::SAMPLE_WIDTH,
  parameter int FRAC_BITS    = lir_pkg::FRAC_BITS,
  parameter int MAX_UPSAMPLE = lir_pkg::MAX_UPSAMPLE
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  lir_in_if.sink                                samples,
  lir_out_if.source                             results,
  input  wire logic                             cfg_we,
  input  wire logic [lir_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lir_pkg::CFG_DATA_W-1:0]   cfg_data
);
  localparam int Q_W = lir_pkg::CTRL_W + 2 * SAMPLE_WIDTH;

  logic [lir_pkg::STEP_W-1:0]     step_q16;
  logic                           bypass;

  logic                           q_push;
  logic                           q_pop;
  logic                           q_full;
  logic                           q_empty;
  lir_pkg::cmd_ctrl_t             f_ctrl;
  logic signed [SAMPLE_WIDTH-1:0] f_a;
  logic signed [SAMPLE_WIDTH-1:0] f_b;
  logic [Q_W-1:0]                 q_wdata;
  logic [Q_W-1:0]                 q_rdata;
  lir_pkg::cmd_ctrl_t             b_ctrl;
  logic signed [SAMPLE_WIDTH-1:0] b_a;
  logic signed [SAMPLE_WIDTH-1:0] b_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_q16 <= lir_pkg::STEP_RESET;
      bypass   <= lir_pkg::BYPASS_RESET;
    end else if (cfg_we) begin
      unique case (lir_pkg::cfg_index_t'(cfg_index))
        lir_pkg::CFG_STEP_Q16: step_q16 <= cfg_data[lir_pkg::STEP_W-1:0];
        lir_pkg::CFG_BYPASS:   bypass   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  lir_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .bypass  (bypass),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_ctrl  (f_ctrl),
    .q_a     (f_a),
    .q_b     (f_b)
  );

  assign q_wdata = {f_ctrl, f_a, f_b};
  assign b_ctrl  = lir_pkg::cmd_ctrl_t'(q_rdata[Q_W-1 -: lir_pkg::CTRL_W]);
  assign b_a     = q_rdata[2*SAMPLE_WIDTH-1 -: SAMPLE_WIDTH];
  assign b_b     = q_rdata[SAMPLE_WIDTH-1:0];

  lir_cmd_fifo #(
    .WIDTH (Q_W),
    .DEPTH (lir_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wdata),
    .pop     (q_pop),
    .rd_data (q_rdata),
    .full    (q_full),
    .empty   (q_empty)
  );

  lir_back #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .FRAC_BITS    (FRAC_BITS),
    .MAX_UPSAMPLE (MAX_UPSAMPLE)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .step_q16 (step_q16),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .q_ctrl   (b_ctrl),
    .q_a      (b_a),
    .q_b      (b_b),
    .results  (results)
  );
endmodule
`default_nettype wire

// ===== hw/rtl/lir_cmd_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lir_cmd_fifo
// Short command queue between the front and the back (DEPTH a power of two).
// ----------------------------------------------------------------------------
module lir_cmd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = lir_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  full,
  output logic                  empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  logic do_push;
  logic do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        mem[wr_ptr] <= wr_data;
        wr_ptr      <= wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/lir_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lir_front
// Accepts input samples, tracks the previous sample and queues one command
// per bypass sample and per sample with a predecessor (copy or interval).
// ----------------------------------------------------------------------------
module lir_front #(
  parameter int SAMPLE_WIDTH = lir_pkg::SAMPLE_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  lir_in_if.sink                              samples,
  input  wire logic                           bypass,
  input  wire logic                           q_full,
  output logic                                q_push,
  output lir_pkg::cmd_ctrl_t                  q_ctrl,
  output logic signed [SAMPLE_WIDTH-1:0]      q_a,
  output logic signed [SAMPLE_WIDTH-1:0]      q_b
);
  logic signed [SAMPLE_WIDTH-1:0] prev_sample;
  logic                           have_prev;
  logic                           accept;

  assign samples.ready = !q_full;
  assign accept        = samples.valid && samples.ready;

  assign q_push      = accept && (bypass || have_prev);
  assign q_ctrl.kind = bypass ? lir_pkg::CMD_BYPASS : lir_pkg::CMD_INTERVAL;
  assign q_ctrl.last = samples.last_sample;
  assign q_a         = bypass ? samples.in_sample : prev_sample;
  assign q_b         = samples.in_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sample <= '0;
      have_prev   <= 1'b0;
    end else if (accept && !bypass) begin
      if (samples.last_sample) begin
        prev_sample <= '0;
        have_prev   <= 1'b0;
      end else begin
        prev_sample <= samples.in_sample;
        have_prev   <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/lir_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lir_back
// Executes queued commands: walks the read position over one interval,
// one product per cycle unless stalled, rounding toward zero into o_sample.
// ----------------------------------------------------------------------------
module lir_back #(
  parameter int SAMPLE_WIDTH = lir_pkg::SAMPLE_WIDTH,
  parameter int FRAC_BITS    = lir_pkg::FRAC_BITS,
  parameter int MAX_UPSAMPLE = lir_pkg::MAX_UPSAMPLE
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic        [lir_pkg::STEP_W-1:0] step_q16,
  input  wire logic                              q_empty,
  output logic                                   q_pop,
  input  wire lir_pkg::cmd_ctrl_t                q_ctrl,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    q_a,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    q_b,
  lir_out_if.source                              results
);
  localparam int SW       = SAMPLE_WIDTH;
  localparam int SE_W     = (lir_pkg::STEP_W > FRAC_BITS) ? lir_pkg::STEP_W : FRAC_BITS;
  localparam int POS_W    = SE_W + 1;
  localparam int N_W      = $clog2(MAX_UPSAMPLE + 1);
  localparam int PROD_W   = SW + FRAC_BITS + 2;
  localparam int MIN_STEP = (2 ** FRAC_BITS + MAX_UPSAMPLE - 1) / MAX_UPSAMPLE;

  localparam logic [POS_W-1:0]  ONE_POS  = POS_W'(1) << FRAC_BITS;
  localparam logic [SE_W-1:0]   STEP_MIN = SE_W'(MIN_STEP);
  localparam logic [PROD_W-1:0] RND_BIAS = PROD_W'(2 ** FRAC_BITS - 1);

  // command under work
  logic                    busy;
  lir_pkg::cmd_ctrl_t      wk_ctrl;
  logic signed [SW-1:0]    wk_a;
  logic signed [SW-1:0]    wk_b;
  logic [N_W-1:0]          n;
  logic [POS_W-1:0]        pos;

  // product stage
  logic                    m_valid;
  logic signed [SW-1:0]    m_a;
  logic signed [PROD_W-1:0] m_prod;
  logic                    m_lor;
  logic                    m_se;

  // output stage
  logic                    o_valid;
  logic signed [SW-1:0]    o_sample;
  logic                    o_lor;
  logic                    o_se;

  logic [SE_W-1:0]         step_eff;
  logic [POS_W-1:0]        pos_next;
  logic [N_W-1:0]          n_next;
  logic                    pos_ge_one;
  logic                    next_ge_one;
  logic                    done;
  logic signed [SW:0]      diff;
  logic signed [FRAC_BITS:0] pfrac;
  logic signed [PROD_W-1:0] prod;
  logic                    o_adv;
  logic                    m_adv;
  logic                    m_free;
  logic                    issue;
  logic signed [PROD_W-1:0] num;
  logic signed [PROD_W-1:0] num_adj;
  logic signed [PROD_W-1:0] quot;

  assign step_eff    = (SE_W'(step_q16) < STEP_MIN) ? STEP_MIN : SE_W'(step_q16);
  assign pos_next    = pos + POS_W'(step_eff);
  assign n_next      = n + N_W'(1);
  assign pos_ge_one  = (pos >= ONE_POS);
  assign next_ge_one = (pos_next >= ONE_POS);
  assign done        = next_ge_one || (n_next == N_W'(MAX_UPSAMPLE));

  assign diff  = {wk_b[SW-1], wk_b} - {wk_a[SW-1], wk_a};
  assign pfrac = $signed({1'b0, pos[FRAC_BITS-1:0]});
  assign prod  = pfrac * diff;

  assign o_adv  = !o_valid || results.ready;
  assign m_adv  = m_valid && o_adv;
  assign m_free = !m_valid || o_adv;
  assign issue  = busy && m_free &&
                  ((wk_ctrl.kind == lir_pkg::CMD_BYPASS) || !pos_ge_one);
  assign q_pop  = !busy && !q_empty;

  assign num     = (PROD_W'(m_a) <<< FRAC_BITS) + m_prod;
  assign num_adj = num + (num[PROD_W-1] ? RND_BIAS : '0);
  assign quot    = num_adj >>> FRAC_BITS;

  assign results.valid       = o_valid;
  assign results.out_sample  = o_sample;
  assign results.last_of_run = o_lor;
  assign results.stream_end  = o_se;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      n       <= '0;
      pos     <= '0;
      m_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        busy    <= 1'b1;
        wk_ctrl <= q_ctrl;
        wk_a    <= q_a;
        wk_b    <= q_b;
        n       <= '0;
      end else if (busy) begin
        unique case (wk_ctrl.kind)
          lir_pkg::CMD_BYPASS: begin
            if (m_free) begin
              busy <= 1'b0;
            end
          end
          lir_pkg::CMD_INTERVAL: begin
            if (pos_ge_one) begin
              busy <= 1'b0;
              pos  <= wk_ctrl.last ? '0 : pos - ONE_POS;
            end else if (m_free) begin
              if (done) begin
                busy <= 1'b0;
                pos  <= (wk_ctrl.last || !next_ge_one) ? '0 : pos_next - ONE_POS;
              end else begin
                pos <= pos_next;
                n   <= n_next;
              end
            end
          end
          default: begin
            busy <= 1'b0;
          end
        endcase
      end

      if (issue) begin
        m_valid <= 1'b1;
        if (wk_ctrl.kind == lir_pkg::CMD_BYPASS) begin
          m_a    <= wk_b;
          m_prod <= '0;
          m_lor  <= 1'b1;
          m_se   <= wk_ctrl.last;
        end else begin
          m_a    <= wk_a;
          m_prod <= prod;
          m_lor  <= done;
          m_se   <= done && wk_ctrl.last;
        end
      end else if (m_adv) begin
        m_valid <= 1'b0;
      end

      if (o_adv) begin
        o_valid  <= m_valid;
        o_sample <= quot[SW-1:0];
        o_lor    <= m_lor;
        o_se     <= m_se;
      end
    end
  end

  a_end_marks_run: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> (!o_se || o_lor))
    else $error("stream end without end of run");

  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> (n < N_W'(MAX_UPSAMPLE)))
    else $error("result count per input exceeds bound");

  a_m_hold: assert property (@(posedge clk) disable iff (rst)
    (m_valid && !o_adv) |=> (m_valid && $stable(m_prod) && $stable(m_a)))
    else $error("product stage lost data under stall");

  a_pos_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (busy && wk_ctrl.kind == lir_pkg::CMD_INTERVAL && n != '0) |-> !pos_ge_one)
    else $error("position left interval without ending run");
endmodule
`default_nettype wire
